>>> design/bfl_pkg.sv
package bfl_pkg;

  localparam int unsigned NODE_W           = 8;
  localparam int unsigned SIZE_W           = 32;
  localparam int unsigned GUARD_W          = 2;
  localparam int unsigned TOTAL_W          = 32;
  localparam int unsigned CLASS_W          = 5;
  localparam int unsigned NODE_COUNT_DEF   = 256;
  localparam int unsigned BUCKET_COUNT_DEF = 20;
  localparam logic [SIZE_W-1:0] SMALL_LIMIT = 32'h20;
  localparam int unsigned SHIFT_BASE       = 5;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_CLEAR,
    STEP_LOAD,
    STEP_INS_WR,
    STEP_INS_LINK,
    STEP_UNL_RD,
    STEP_FIN
  } bfl_step_e;

  typedef struct packed {
    bfl_step_e step;
  } bfl_cmd_t;

  typedef struct packed {
    logic ins_go;      // insert of a real node
    logic unl_go;      // unlink of a real node
    logic clear_last;  // clearing sweep on its last entry
  } bfl_sts_t;

  // 0 below SMALL_LIMIT, else floor(log2(size)) - 4, capped at cap.
  function automatic logic [CLASS_W-1:0] size_class(input logic [SIZE_W-1:0] size,
                                                    input logic [CLASS_W-1:0] cap);
    logic [CLASS_W-1:0] msb;
    logic [CLASS_W-1:0] cls;
    msb = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (size[i]) begin
        msb = CLASS_W'(i);
      end
    end
    if (size < SMALL_LIMIT) begin
      cls = '0;
    end else begin
      cls = msb - CLASS_W'(SHIFT_BASE - 1);
      if (cls > cap) begin
        cls = cap;
      end
    end
    return cls;
  endfunction

endpackage

>>> design/bfl_req_if.sv
interface bfl_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [bfl_pkg::NODE_W-1:0]   anchor_node;
  logic [bfl_pkg::NODE_W-1:0]   target_node;
  logic [bfl_pkg::SIZE_W-1:0]   block_size;

  modport source (output valid, cmd, anchor_node, target_node, block_size, input ready);
  modport sink   (input valid, cmd, anchor_node, target_node, block_size, output ready);
endinterface

>>> design/bfl_rsp_if.sv
interface bfl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bfl_pkg::NODE_W-1:0]    result_node;
  logic [bfl_pkg::GUARD_W-1:0]   guards_fired;
  logic [bfl_pkg::TOTAL_W-1:0]   guard_total;

  modport source (output valid, result_node, guards_fired, guard_total, input ready);
  modport sink   (input valid, result_node, guards_fired, guard_total, output ready);
endinterface

>>> design/bfl_ctrl.sv
module bfl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  input  bfl_pkg::bfl_sts_t sts_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output bfl_pkg::bfl_cmd_t cmd_o
);
  import bfl_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR    = 5'b00001,
    ST_IDLE     = 5'b00010,
    ST_FIRST    = 5'b00100,
    ST_INS_LINK = 5'b01000,
    ST_FINISH   = 5'b10000
  } bfl_state_e;

  bfl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       can_push;

  assign can_push    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.step  = STEP_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.step = STEP_CLEAR;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.step = STEP_LOAD;
          state_d    = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (sts_i.ins_go) begin
          cmd_o.step = STEP_INS_WR;
          state_d    = ST_INS_LINK;
        end else if (sts_i.unl_go) begin
          cmd_o.step = STEP_UNL_RD;
          state_d    = ST_FINISH;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_INS_LINK: begin
        cmd_o.step = STEP_INS_LINK;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        // commit only once the output register can take the result
        if (can_push) begin
          cmd_o.step  = STEP_FIN;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> design/bfl_dp.sv
module bfl_dp #(
  parameter int unsigned NODE_COUNT   = bfl_pkg::NODE_COUNT_DEF,
  parameter int unsigned BUCKET_COUNT = bfl_pkg::BUCKET_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bfl_pkg::bfl_cmd_t            cmd_i,
  output bfl_pkg::bfl_sts_t            sts_o,
  input  logic                         cmd_bit_i,
  input  logic [bfl_pkg::NODE_W-1:0]   anchor_node_i,
  input  logic [bfl_pkg::NODE_W-1:0]   target_node_i,
  input  logic [bfl_pkg::SIZE_W-1:0]   block_size_i,
  output logic [bfl_pkg::NODE_W-1:0]   result_node_o,
  output logic [bfl_pkg::GUARD_W-1:0]  guards_fired_o,
  output logic [bfl_pkg::TOTAL_W-1:0]  guard_total_o
);
  import bfl_pkg::*;

  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam int unsigned BW = $clog2(BUCKET_COUNT);
  localparam logic [CLASS_W-1:0] CLASS_CAP = CLASS_W'(BUCKET_COUNT - 1);

  function automatic logic [NODE_W-1:0] node_of(input logic [NODE_W-1:0] n);
    return ({24'd0, n} < 32'(NODE_COUNT)) ? n : '0;
  endfunction

  function automatic logic [NW-1:0] addr_of(input logic [NODE_W-1:0] n);
    logic [NW+NODE_W-1:0] ext;
    ext = {{NW{1'b0}}, n};
    return ext[NW-1:0];
  endfunction

  // node tables
  logic [NODE_W-1:0] next_mem [NODE_COUNT];
  logic [NODE_W-1:0] prev_mem [NODE_COUNT];
  logic [SIZE_W-1:0] size_mem [NODE_COUNT];

  logic              next_we, prev_we, size_we;
  logic [NW-1:0]     next_wa, prev_wa, size_wa;
  logic [NODE_W-1:0] next_wd, prev_wd;
  logic [SIZE_W-1:0] size_wd;
  logic              next_re, prev_re, size_re;
  logic [NW-1:0]     next_ra, prev_ra, size_ra;
  logic [NODE_W-1:0] next_rd_q, prev_rd_q;
  logic [SIZE_W-1:0] size_rd_q;

  // request and working registers
  logic              cmd_q;
  logic [NODE_W-1:0] self_q, node_q, nx_q, pv_q;
  logic [SIZE_W-1:0] size_q;
  logic [BW-1:0]     cls_q;
  logic [NODE_W-1:0] result_q;
  logic [GUARD_W-1:0] guards_q;
  logic [TOTAL_W-1:0] total_q;
  logic [NW-1:0]     clr_q;
  logic [NODE_W-1:0] bucket_q [BUCKET_COUNT];

  logic [NODE_W-1:0]  anchor_n;
  logic [CLASS_W-1:0] cls_in, cls_rd;
  logic [NODE_W-1:0]  ins_nx, head, nxh;
  logic               unl_prev_ok, unl_next_ok;
  logic               fin_bucket_we;
  logic [NODE_W-1:0]  fin_bucket_wd, fin_result;
  logic [GUARD_W-1:0] fin_guards;

  assign anchor_n = node_of(anchor_node_i);
  assign cls_in   = size_class(block_size_i, CLASS_CAP);
  assign cls_rd   = size_class(size_rd_q, CLASS_CAP);
  assign ins_nx   = (self_q != '0) ? next_rd_q : '0;
  assign head     = bucket_q[cls_q];
  // next[self] is rewritten in the same cycle the head's successor is read
  assign nxh      = (self_q != '0 && head == self_q) ? node_q : next_rd_q;
  assign unl_prev_ok = (nx_q != '0) && (prev_rd_q == self_q);
  assign unl_next_ok = (pv_q != '0) && (next_rd_q == self_q);

  assign sts_o.ins_go     = !cmd_q && (node_q != '0);
  assign sts_o.unl_go     = cmd_q && (self_q != '0);
  assign sts_o.clear_last = (clr_q == NW'(NODE_COUNT - 1));

  always_comb begin
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    size_we = 1'b0; size_wa = '0; size_wd = '0;
    next_re = 1'b0; next_ra = '0;
    prev_re = 1'b0; prev_ra = '0;
    size_re = 1'b0; size_ra = '0;
    case (cmd_i.step)
      STEP_CLEAR: begin
        next_we = 1'b1; next_wa = clr_q;
        prev_we = 1'b1; prev_wa = clr_q;
        size_we = 1'b1; size_wa = clr_q;
      end
      STEP_LOAD: begin
        next_re = 1'b1; next_ra = addr_of(anchor_n);
        prev_re = 1'b1; prev_ra = addr_of(anchor_n);
        size_re = 1'b1; size_ra = addr_of(anchor_n);
      end
      STEP_INS_WR: begin
        next_we = 1'b1; next_wa = addr_of(node_q); next_wd = ins_nx;
        prev_we = 1'b1; prev_wa = addr_of(node_q); prev_wd = self_q;
        size_we = 1'b1; size_wa = addr_of(node_q); size_wd = size_q;
      end
      STEP_INS_LINK: begin
        next_we = (self_q != '0); next_wa = addr_of(self_q); next_wd = node_q;
        prev_we = (nx_q != '0);   prev_wa = addr_of(nx_q);   prev_wd = node_q;
        next_re = 1'b1; next_ra = addr_of(head);
        size_re = 1'b1; size_ra = addr_of(head);
      end
      STEP_UNL_RD: begin
        next_re = 1'b1; next_ra = addr_of(prev_rd_q);
        prev_re = 1'b1; prev_ra = addr_of(next_rd_q);
        size_re = 1'b1; size_ra = addr_of(next_rd_q);
      end
      STEP_FIN: begin
        if (cmd_q && self_q != '0) begin
          prev_we = unl_prev_ok; prev_wa = addr_of(nx_q); prev_wd = pv_q;
          next_we = unl_next_ok; next_wa = addr_of(pv_q); next_wd = nx_q;
        end
      end
      default: begin
        next_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    fin_bucket_we = 1'b0;
    fin_bucket_wd = node_q;
    fin_result    = '0;
    fin_guards    = GUARD_W'(1);
    if (!cmd_q) begin
      if (node_q != '0) begin
        fin_result    = node_q;
        fin_guards    = GUARD_W'((self_q == '0) || (nx_q == '0));
        fin_bucket_we = (head == '0) || (nxh == '0) || (size_rd_q > size_q);
      end
    end else if (self_q != '0) begin
      fin_result = self_q;
      fin_guards = GUARD_W'(!unl_prev_ok) + GUARD_W'(!unl_next_ok);
      if (head == self_q) begin
        fin_result    = nx_q;
        fin_bucket_we = 1'b1;
        if (nx_q == '0) begin
          fin_bucket_wd = '0;
          fin_guards    = fin_guards + GUARD_W'(1);
        end else begin
          // successor in another size class leaves the bucket empty
          fin_bucket_wd = (cls_q != cls_rd[BW-1:0]) ? '0 : nx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (next_re) next_rd_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (prev_re) prev_rd_q <= prev_mem[prev_ra];
  end

  always_ff @(posedge clk_i) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    if (size_re) size_rd_q <= size_mem[size_ra];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      STEP_LOAD: begin
        cmd_q  <= cmd_bit_i;
        self_q <= anchor_n;
        node_q <= node_of(target_node_i);
        size_q <= block_size_i;
        cls_q  <= cls_in[BW-1:0];
      end
      STEP_INS_WR: begin
        nx_q <= ins_nx;
      end
      STEP_UNL_RD: begin
        nx_q  <= next_rd_q;
        pv_q  <= prev_rd_q;
        cls_q <= cls_rd[BW-1:0];
      end
      STEP_FIN: begin
        result_q <= fin_result;
        guards_q <= fin_guards;
      end
      default: begin
        result_q <= result_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      clr_q   <= '0;
      for (int i = 0; i < BUCKET_COUNT; i++) begin
        bucket_q[i] <= '0;
      end
    end else begin
      if (cmd_i.step == STEP_CLEAR) begin
        clr_q <= clr_q + NW'(1);
      end
      if (cmd_i.step == STEP_FIN) begin
        total_q <= total_q + TOTAL_W'(fin_guards);
        if (fin_bucket_we) begin
          bucket_q[cls_q] <= fin_bucket_wd;
        end
      end
    end
  end

  assign result_node_o  = result_q;
  assign guards_fired_o = guards_q;
  assign guard_total_o  = total_q;

endmodule

>>> design/bucketed_free_list_link_engine.sv
// Segregated free-list link engine: node tables of next link, previous link
// and size, plus one head per size class. A request either inserts
// target_node after anchor_node or unlinks anchor_node, and returns a node,
// the guard hits of that request and the running guard total. After reset
// the node tables are swept to zero, one entry a cycle, over all NODE_COUNT
// entries (256 by default) with req ready low. Then one request is worked at
// a time. Its steps follow the dependent accesses to the node tables, each
// with one read and one write port. An insert reads the anchor, writes the
// new node, writes the neighbours' links while reading the bucket head, then
// commits; an unlink reads the anchor, then its neighbours, then commits.
// A result sits in an output register, so the next request is taken while it
// waits; that request stalls in its commit cycle only if the result is still
// untaken.
module bucketed_free_list_link_engine #(
  parameter int unsigned NODE_COUNT   = bfl_pkg::NODE_COUNT_DEF,
  parameter int unsigned BUCKET_COUNT = bfl_pkg::BUCKET_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfl_req_if.sink     req_i,
  bfl_rsp_if.source   rsp_o
);
  import bfl_pkg::*;

  bfl_cmd_t cmd;
  bfl_sts_t sts;

  bfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  bfl_dp #(
    .NODE_COUNT   (NODE_COUNT),
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cmd_bit_i      (req_i.cmd),
    .anchor_node_i  (req_i.anchor_node),
    .target_node_i  (req_i.target_node),
    .block_size_i   (req_i.block_size),
    .result_node_o  (rsp_o.result_node),
    .guards_fired_o (rsp_o.guards_fired),
    .guard_total_o  (rsp_o.guard_total)
  );

endmodule

>>> design/bfl_checker.sv
module bfl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [bfl_pkg::NODE_W-1:0]   result_node_i,
  input logic [bfl_pkg::GUARD_W-1:0]  guards_fired_i,
  input logic [bfl_pkg::TOTAL_W-1:0]  guard_total_i
);
  import bfl_pkg::*;

  logic               in_acc, out_acc;
  logic [1:0]         pend_q;
  logic [TOTAL_W-1:0] last_total_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      last_total_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        last_total_q <= guard_total_i;
      end
    end
  end

  // one request in work at a time
  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("request accepted while another is in work");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_node_i) &&
      $stable(guards_fired_i) && $stable(guard_total_i))
    else $error("stalled result changed");

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without a pending request");

  a_total_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> guard_total_i == last_total_q + TOTAL_W'(guards_fired_i))
    else $error("guard total does not follow guard hits");

endmodule

bind bucketed_free_list_link_engine bfl_checker u_bfl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .result_node_i  (rsp_o.result_node),
  .guards_fired_i (rsp_o.guards_fired),
  .guard_total_i  (rsp_o.guard_total)
);

>>> tb/sv/tb_bucketed_free_list_link_engine.sv
`timescale 1ns / 1ps

module tb_bucketed_free_list_link_engine;
  import bfl_pkg::*;

  localparam int unsigned NODES       = NODE_COUNT_DEF;
  localparam int unsigned BUCKETS     = BUCKET_COUNT_DEF;
  localparam logic        OP_INSERT   = 1'b0;
  localparam logic        OP_UNLINK   = 1'b1;
  localparam int unsigned IDLE_PCT    = 28;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [GUARD_W-1:0] guards;
    logic [TOTAL_W-1:0] total;
  } link_result_t;

  logic clk_i;
  logic rst_ni;

  bfl_req_if req_bus ();
  bfl_rsp_if rsp_bus ();

  bucketed_free_list_link_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Shadow copy of the engine's tables
  logic [NODE_W-1:0]  next_tab [NODES];
  logic [NODE_W-1:0]  prev_tab [NODES];
  logic [SIZE_W-1:0]  size_tab [NODES];
  logic [NODE_W-1:0]  head_tab [BUCKETS];
  logic [TOTAL_W-1:0] guard_sum;

  link_result_t expected_links [$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  logic         no_idle;

  // Nodes the list-shaped stimulus believes are linked
  int unsigned  live_q [$];
  logic         live_flag [NODES];

  function automatic int unsigned bucket_of(input logic [SIZE_W-1:0] s);
    int unsigned top;
    top = 0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (s[i]) begin
        top = i;
      end
    end
    if (s < SMALL_LIMIT) begin
      return 0;
    end
    if (top - (SHIFT_BASE - 1) > BUCKETS - 1) begin
      return BUCKETS - 1;
    end
    return top - (SHIFT_BASE - 1);
  endfunction

  function automatic link_result_t predict_link_op(input logic op,
                                                   input logic [NODE_W-1:0] anchor,
                                                   input logic [NODE_W-1:0] target,
                                                   input logic [SIZE_W-1:0] blk_size);
    link_result_t r;
    logic [NODE_W-1:0] nx;
    logic [NODE_W-1:0] pv;
    logic [NODE_W-1:0] hd;
    int unsigned g;
    int unsigned b;
    g = 0;
    if (op == OP_INSERT) begin
      r.node = target;
      if (target == '0) begin
        g++;
      end else begin
        if (anchor != '0) begin
          nx = next_tab[anchor];
          next_tab[target] = nx;
          prev_tab[target] = anchor;
          if (nx != '0) begin
            prev_tab[nx] = target;
          end else begin
            g++;
          end
          next_tab[anchor] = target;
        end else begin
          next_tab[target] = '0;
          prev_tab[target] = '0;
          g++;
        end
        size_tab[target] = blk_size;
        b = bucket_of(blk_size);
        hd = head_tab[b];
        if (hd == '0 || next_tab[hd] == '0 || size_tab[hd] > blk_size) begin
          head_tab[b] = target;
        end
      end
    end else if (anchor == '0) begin
      g++;
      r.node = '0;
    end else begin
      nx = next_tab[anchor];
      pv = prev_tab[anchor];
      if (nx != '0 && prev_tab[nx] == anchor) begin
        prev_tab[nx] = pv;
      end else begin
        g++;
      end
      if (pv != '0 && next_tab[pv] == anchor) begin
        next_tab[pv] = nx;
      end else begin
        g++;
      end
      r.node = anchor;
      b = bucket_of(size_tab[anchor]);
      if (head_tab[b] == anchor) begin
        r.node = nx;
        if (nx == '0) begin
          head_tab[b] = '0;
          g++;
        end else begin
          // successor of another class leaves the bucket empty
          head_tab[b] = (bucket_of(size_tab[nx]) != b) ? '0 : nx;
        end
      end
    end
    guard_sum = guard_sum + g;
    r.guards = GUARD_W'(g);
    r.total  = guard_sum;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic op, input logic [NODE_W-1:0] anchor,
                              input logic [NODE_W-1:0] target,
                              input logic [SIZE_W-1:0] blk_size);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.cmd         <= op;
    req_bus.anchor_node <= anchor;
    req_bus.target_node <= target;
    req_bus.block_size  <= blk_size;
    @(posedge clk_i);
    while (!req_bus.ready) begin
      @(posedge clk_i);
    end
    expected_links.push_back(predict_link_op(op, anchor, target, blk_size));
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    req_bus.valid <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (expected_links.size() != 0);
  endtask

  function automatic logic [SIZE_W-1:0] pick_block_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(31);
      default: return $urandom >> $urandom_range(31, 12);
    endcase
  endfunction

  always @(negedge clk_i) begin
    rsp_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    link_result_t exp_r;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_links.size() == 0) begin
        $display("%0t: result with nothing pending: node %0d guards %0d total %0d", $time,
                 rsp_bus.result_node, rsp_bus.guards_fired, rsp_bus.guard_total);
        error_count++;
      end else begin
        exp_r = expected_links.pop_front();
        if (rsp_bus.result_node !== exp_r.node) begin
          $display("%0t: result_node expected %0d, got %0d", $time, exp_r.node,
                   rsp_bus.result_node);
          error_count++;
        end
        if (rsp_bus.guards_fired !== exp_r.guards) begin
          $display("%0t: guards_fired expected %0d, got %0d", $time, exp_r.guards,
                   rsp_bus.guards_fired);
          error_count++;
        end
        if (rsp_bus.guard_total !== exp_r.total) begin
          $display("%0t: guard_total expected %0d, got %0d", $time, exp_r.total,
                   rsp_bus.guard_total);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, expected_links.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_insert_guards();
    send_request(OP_INSERT, 8'd5, 8'd0, 32'd7);           // null node
    send_request(OP_INSERT, 8'd0, 8'd1, 32'd0);           // null anchor
    send_request(OP_INSERT, 8'd1, 8'd2, 32'd31);          // anchor without successor
    send_request(OP_INSERT, 8'd1, 8'd3, 32'h20);
    send_request(OP_INSERT, 8'd3, 8'd255, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 8'd255, 8'd4, 32'h8000_0000); // smaller size takes the head
  endtask

  task automatic test_bucket_heads();
    send_request(OP_INSERT, 8'd1, 8'd10, 32'd100);
    send_request(OP_INSERT, 8'd10, 8'd11, 32'd64);
    send_request(OP_INSERT, 8'd10, 8'd12, 32'd127);
    send_request(OP_INSERT, 8'd12, 8'd13, 32'd70);
    send_request(OP_INSERT, 8'd0, 8'd20, 32'h0001_0000);
  endtask

  task automatic test_unlink_cases();
    send_request(OP_UNLINK, 8'd0, 8'd9, 32'd1);   // null node
    send_request(OP_UNLINK, 8'd200, 8'd0, 32'd0); // never linked
    send_request(OP_UNLINK, 8'd20, 8'd0, 32'd0);  // lone head, empty successor
    send_request(OP_UNLINK, 8'd11, 8'd0, 32'd0);
    send_request(OP_UNLINK, 8'd3, 8'd0, 32'd0);
    send_request(OP_UNLINK, 8'd3, 8'd0, 32'd0);   // stale back-links now
    send_request(OP_UNLINK, 8'd4, 8'd0, 32'd0);
    send_request(OP_UNLINK, 8'd255, 8'd0, 32'd0);
  endtask

  task automatic test_self_reference();
    send_request(OP_INSERT, 8'd30, 8'd30, 32'd50);
    send_request(OP_INSERT, 8'd31, 8'd31, 32'd0);
    send_request(OP_UNLINK, 8'd30, 8'd30, 32'd0);
    send_request(OP_INSERT, 8'd30, 8'd31, 32'd40);
  endtask

  task automatic test_drain_pause();
    send_request(OP_INSERT, 8'd0, 8'd40, 32'd300);
    send_request(OP_INSERT, 8'd40, 8'd41, 32'd300);
    wait_for_drain();
    send_request(OP_UNLINK, 8'd40, 8'd0, 32'd0);
    send_request(OP_UNLINK, 8'd41, 8'd0, 32'd0);
  endtask

  task automatic send_noise();
    send_request(1'($urandom), 8'($urandom), 8'($urandom), $urandom);
  endtask

  // Mostly consistent insert/unlink sequences on a small node pool, at times widened to all nodes
  task automatic test_random_lists(input int unsigned count);
    int unsigned pool_top;
    int unsigned roll;
    int unsigned pick;
    int unsigned idx;
    int unsigned anchor;
    pool_top = 15;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        pool_top = ($urandom_range(3) == 0) ? NODES - 1 : 15;
      end
      no_idle = (n >= 300 && n < 500);
      roll = $urandom_range(99);
      pick = 0;
      if (roll >= 10 && (roll < 55 || live_q.size() == 0)) begin
        for (int t = 0; t < 8 && pick == 0; t++) begin
          idx = $urandom_range(pool_top, 1);
          if (!live_flag[idx]) begin
            pick = idx;
          end
        end
      end
      if (roll < 10) begin
        send_noise();
      end else if (pick != 0) begin
        anchor = 0;
        if (live_q.size() != 0 && $urandom_range(9) != 0) begin
          anchor = live_q[$urandom_range(live_q.size() - 1)];
        end
        live_q.push_back(pick);
        live_flag[pick] = 1'b1;
        send_request(OP_INSERT, NODE_W'(anchor), NODE_W'(pick), pick_block_size());
      end else if (live_q.size() != 0) begin
        idx  = $urandom_range(live_q.size() - 1);
        pick = live_q[idx];
        live_q.delete(idx);
        live_flag[pick] = 1'b0;
        send_request(OP_UNLINK, NODE_W'(pick), 8'($urandom), $urandom);
      end else begin
        send_noise();
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_noise(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      send_noise();
    end
  endtask

  initial begin
    for (int i = 0; i < NODES; i++) begin
      next_tab[i]  = '0;
      prev_tab[i]  = '0;
      size_tab[i]  = '0;
      live_flag[i] = 1'b0;
    end
    for (int i = 0; i < BUCKETS; i++) begin
      head_tab[i] = '0;
    end
    guard_sum   = '0;
    error_count = 0;
    cycle_count = 0;
    no_idle     = 1'b0;
    rst_ni      = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.cmd         = OP_INSERT;
    req_bus.anchor_node = '0;
    req_bus.target_node = '0;
    req_bus.block_size  = '0;
    rsp_bus.ready       = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_insert_guards();
    test_bucket_heads();
    test_unlink_cases();
    test_self_reference();
    test_drain_pause();
    test_random_lists(1150);
    test_random_noise(270);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
design/bfl_pkg.sv
design/bfl_req_if.sv
design/bfl_rsp_if.sv
design/bfl_ctrl.sv
design/bfl_dp.sv
design/bucketed_free_list_link_engine.sv
design/bfl_checker.sv
tb/sv/tb_bucketed_free_list_link_engine.sv
